[design/iot_pkg.sv]
package iot_pkg;

	localparam int SLOTS_DEFAULT = 64;

	// request kinds
	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_MODIFY = 3'd2;
	localparam logic [2:0] KIND_LEVEL  = 3'd3;
	localparam logic [2:0] KIND_QUEUE  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNKNOWN   = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_VIS_SHARE = 2'd0;
	localparam logic [1:0] REG_REP_SHARE = 2'd1;
	localparam logic [1:0] REG_HID_MIN   = 2'd2;

	localparam logic [16:0] SHARE_ONE       = 17'd65536;
	localparam logic [16:0] VIS_SHARE_RESET = 17'd52429;
	localparam logic [16:0] REP_SHARE_RESET = 17'd32768;
	localparam logic [30:0] HID_MIN_RESET   = 31'd10;

	// packed slot record: key, symbol, price, total, visible
	localparam int SLOT_W = 32 + 16 + 32 + 32 + 32;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] symbol;
		logic [31:0] price;
		logic [31:0] total;
		logic [31:0] visible;
	} slot_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MUL1,
		S_MUL2,
		S_MOD_RD,
		S_REPL,
		S_WRITE,
		S_OUT
	} state_t;

	// clamp a Q1.16 share to one
	function automatic logic [16:0] clamp_share(input logic [16:0] s);
		clamp_share = (s > SHARE_ONE) ? SHARE_ONE : s;
	endfunction

endpackage

[design/iot_ram.sv]
module iot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/iceberg_order_table.sv]
// Every kind takes the same path: a scan of the slot memory, one slot per cycle, then the
// states S_DECIDE, S_MUL1, S_MUL2, S_MOD_RD, S_REPL and S_WRITE, and S_OUT until taken.
// One transaction at a time: in_stall is high from acceptance until the result is taken,
// so a new transaction is taken only after the result of the last one has left.
// Reset: arst_n clears the valid bits, the controller and the configuration registers;
// slot memory contents are left undefined and only used for valid slots.
module iceberg_order_table import iot_pkg::*; #(
	parameter int ORDER_SLOTS = SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [31:0]        order_key,
	input  logic [15:0]        symbol_code,
	input  logic [31:0]        price_ticks,
	input  logic [30:0]        add_quantity,
	input  logic               is_iceberg,
	input  logic signed [31:0] qty_change,
	input  logic               visible_side,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] queried_quantity,
	output logic signed [31:0] order_total,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(ORDER_SLOTS);
	localparam int CW = $clog2(ORDER_SLOTS + 1);
	localparam logic [CW-1:0] LAST = CW'(ORDER_SLOTS - 1);

	// configuration registers
	logic [16:0] vis_share_q, rep_share_q;
	logic [30:0] hid_min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_share_q <= VIS_SHARE_RESET;
			rep_share_q <= REP_SHARE_RESET;
			hid_min_q   <= HID_MIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VIS_SHARE: vis_share_q <= cfg_data[16:0];
				REG_REP_SHARE: rep_share_q <= cfg_data[16:0];
				REG_HID_MIN:   hid_min_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// captured request
	logic [2:0]  kind_q;
	logic [31:0] key_q, price_q, delta_q;
	logic [15:0] sym_q;
	logic [30:0] addq_q;
	logic        ice_q, vis_q;

	// control and scan state
	state_t      state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic        rd_valid_s1;
	logic [AW-1:0] rd_addr_s1;
	logic        found_q, free_q;
	logic [AW-1:0] hit_q, free_slot_q;
	slot_t       hit_rec_q;
	logic [31:0] sum_q;
	logic [ORDER_SLOTS-1:0] valid_q;

	// result register
	logic [1:0]  status_q;
	logic [31:0] queried_q, total_q;

	// arithmetic staging
	logic [47:0] prod_q;
	logic [31:0] new_total_q, hidden_q;
	logic        do_mul_q;

	// slot memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	slot_t         ram_wdata, ram_rdata;
	logic [SLOT_W-1:0] ram_rbits;

	iot_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);
	assign ram_rdata = slot_t'(ram_rbits);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status           = status_q;
	assign queried_quantity = queried_q;
	assign order_total      = total_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SCAN;
			S_SCAN:   if (cnt_q == CW'(ORDER_SLOTS)) state_d = S_DECIDE;
			S_DECIDE: state_d = S_MUL1;
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = S_MOD_RD;
			S_MOD_RD: state_d = S_REPL;
			S_REPL:   state_d = S_WRITE;
			S_WRITE:  state_d = S_OUT;
			S_OUT:    if (!out_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// read address walks the table during the scan
	assign ram_raddr = cnt_q[AW-1:0];

	// replenish decision on the modified record
	logic [31:0] mod_total, mod_hidden;
	logic        repl_all;
	always_comb begin
		mod_total   = hit_rec_q.total + delta_q;
		mod_hidden  = mod_total - hit_rec_q.visible;
		repl_all    = $signed(mod_hidden) <= $signed({1'b0, hid_min_q});
	end

	// write back of a slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_q;
		ram_wdata = hit_rec_q;
		if (state_q == S_WRITE && status_q == ST_OK) begin
			if (kind_q == KIND_ADD) begin
				ram_we            = 1'b1;
				ram_waddr         = free_slot_q;
				ram_wdata.key     = key_q;
				ram_wdata.symbol  = sym_q;
				ram_wdata.price   = price_q;
				ram_wdata.total   = {1'b0, addq_q};
				ram_wdata.visible = ice_q ? prod_q[47:16] : {1'b0, addq_q};
			end else if (kind_q == KIND_MODIFY) begin
				ram_we            = 1'b1;
				ram_wdata.total   = new_total_q;
				if (vis_q) begin
					ram_wdata.visible = hit_rec_q.visible + delta_q;
				end else if (hit_rec_q.visible == 32'd0) begin
					ram_wdata.visible = do_mul_q ? prod_q[47:16] : hidden_q;
				end else begin
					ram_wdata.visible = hit_rec_q.visible;
				end
			end
		end
	end

	logic [16:0] mul_share;
	logic [31:0] mul_arg;
	assign mul_share = (kind_q == KIND_ADD) ? clamp_share(vis_share_q)
		: clamp_share(rep_share_q);
	assign mul_arg = (kind_q == KIND_ADD) ? {1'b0, addq_q} : hidden_q;

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			sum_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					cnt_q       <= '0;
					rd_valid_s1 <= 1'b0;
					found_q     <= 1'b0;
					free_q      <= 1'b0;
					sum_q       <= '0;
				end
				S_SCAN: begin
					rd_valid_s1 <= (cnt_q <= LAST);
					rd_addr_s1  <= cnt_q[AW-1:0];
					if (cnt_q != CW'(ORDER_SLOTS)) begin
						cnt_q <= cnt_q + CW'(1);
					end
					// lowest free slot, from the valid bits
					if (cnt_q <= LAST && !valid_q[cnt_q[AW-1:0]] && !free_q) begin
						free_q      <= 1'b1;
						free_slot_q <= cnt_q[AW-1:0];
					end
					if (rd_valid_s1 && valid_q[rd_addr_s1]) begin
						if (ram_rdata.key == key_q && !found_q) begin
							found_q   <= 1'b1;
							hit_q     <= rd_addr_s1;
							hit_rec_q <= ram_rdata;
						end
						if (ram_rdata.symbol == sym_q && ram_rdata.price == price_q) begin
							sum_q <= sum_q + ram_rdata.visible;
						end
					end
				end
				S_WRITE: begin
					if (status_q == ST_OK && kind_q == KIND_ADD) begin
						valid_q[free_slot_q] <= 1'b1;
					end else if (status_q == ST_OK && kind_q == KIND_REMOVE) begin
						valid_q[hit_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q  <= kind;
				key_q   <= order_key;
				sym_q   <= symbol_code;
				price_q <= price_ticks;
				addq_q  <= add_quantity;
				ice_q   <= is_iceberg;
				delta_q <= qty_change;
				vis_q   <= visible_side;
			end
			S_DECIDE: begin
				status_q  <= ST_OK;
				queried_q <= '0;
				total_q   <= '0;
				do_mul_q  <= 1'b0;
				case (kind_q) inside
					KIND_ADD: begin
						if (found_q) begin
							status_q <= ST_DUPLICATE;
							total_q  <= hit_rec_q.total;
						end else if (!free_q) begin
							status_q <= ST_FULL;
						end else begin
							total_q <= {1'b0, addq_q};
						end
					end
					KIND_REMOVE, KIND_MODIFY: begin
						if (!found_q) status_q <= ST_UNKNOWN;
					end
					KIND_LEVEL: queried_q <= sum_q;
					KIND_QUEUE: begin
						if (!found_q) begin
							status_q <= ST_UNKNOWN;
						end else begin
							queried_q <= vis_q ? hit_rec_q.visible
								: hit_rec_q.total - hit_rec_q.visible;
							total_q   <= hit_rec_q.total;
						end
					end
					default: ;
				endcase
			end
			S_MUL1: begin
				new_total_q <= mod_total;
				hidden_q    <= mod_hidden;
				if (kind_q == KIND_MODIFY && status_q == ST_OK) begin
					total_q  <= mod_total;
					do_mul_q <= !repl_all;
				end
			end
			S_MUL2: begin
				prod_q <= {16'd0, mul_arg} * {31'd0, mul_share};
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while input open");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && status_q == ST_OK && kind_q == KIND_ADD) |-> free_q)
		else $error("add written without a free slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (cnt_q == CW'(ORDER_SLOTS)))
		else $error("decision before the scan ended");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_stall) |=> $stable(status_q) && $stable(total_q))
		else $error("held result changed");

endmodule

[tb/sv/iceberg_order_table_tb.sv]
`timescale 1ns / 100ps

module iceberg_order_table_tb import iot_pkg::*;;

	localparam int SLOTS = SLOTS_DEFAULT;
	localparam int DRAIN_CYCLES = SLOTS + 20;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic [31:0]        order_key;
	logic [15:0]        symbol_code;
	logic [31:0]        price_ticks;
	logic [30:0]        add_quantity;
	logic               is_iceberg;
	logic signed [31:0] qty_change;
	logic               visible_side;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] queried_quantity;
	logic signed [31:0] order_total;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] queried;
		logic [31:0] total;
	} answer_t;

	// book model
	bit          book_live [SLOTS];
	logic [31:0] book_key [SLOTS];
	logic [15:0] book_sym [SLOTS];
	logic [31:0] book_price [SLOTS];
	logic [31:0] book_total [SLOTS];
	logic [31:0] book_vis [SLOTS];
	logic [16:0] vis_share;
	logic [16:0] rep_share;
	logic [30:0] hid_min;

	answer_t answers_due [$];
	int      mismatch_count;
	int      answers_seen;
	bit      long_hold;

	iceberg_order_table dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] take_share(logic [31:0] q, logic [16:0] sh);
		logic [63:0] prod;
		prod = {32'd0, q} * {47'd0, (sh > SHARE_ONE) ? SHARE_ONE : sh};
		return prod[47:16];
	endfunction

	function automatic int find_order(logic [31:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (book_live[i] && book_key[i] == k)
				return i;
		return -1;
	endfunction

	// work out the answer to one request and update the book
	function automatic answer_t apply_request(logic [2:0] kd, logic [31:0] k, logic [15:0] sym,
			logic [31:0] pr, logic [30:0] aq, logic ice, logic [31:0] dq, logic vis);
		answer_t a;
		int s;
		int f;
		logic [31:0] hidden;
		a = '{ST_OK, 32'd0, 32'd0};
		s = find_order(k);
		f = -1;
		case (kd)
			KIND_ADD: begin
				if (s >= 0) begin
					a.status = ST_DUPLICATE;
					a.total = book_total[s];
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!book_live[i])
							f = i;
					if (f < 0) begin
						a.status = ST_FULL;
					end else begin
						book_live[f] = 1'b1;
						book_key[f] = k;
						book_sym[f] = sym;
						book_price[f] = pr;
						book_total[f] = {1'b0, aq};
						book_vis[f] = ice ? take_share({1'b0, aq}, vis_share) : {1'b0, aq};
						a.total = {1'b0, aq};
					end
				end
			end
			KIND_REMOVE: begin
				if (s < 0)
					a.status = ST_UNKNOWN;
				else
					book_live[s] = 1'b0;
			end
			KIND_MODIFY: begin
				if (s < 0) begin
					a.status = ST_UNKNOWN;
				end else begin
					book_total[s] += dq;
					if (vis) begin
						book_vis[s] += dq;
					end else if (book_vis[s] == 32'd0) begin
						hidden = book_total[s];
						if ($signed(hidden) <= $signed({1'b0, hid_min}))
							book_vis[s] = hidden;
						else
							book_vis[s] = take_share(hidden, rep_share);
					end
					a.total = book_total[s];
				end
			end
			KIND_LEVEL: begin
				for (int i = 0; i < SLOTS; i++)
					if (book_live[i] && book_sym[i] == sym && book_price[i] == pr)
						a.queried += book_vis[i];
			end
			KIND_QUEUE: begin
				if (s < 0) begin
					a.status = ST_UNKNOWN;
				end else begin
					a.queried = vis ? book_vis[s] : book_total[s] - book_vis[s];
					a.total = book_total[s];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// send one request, predicting its answer at acceptance
	task automatic send_request(logic [2:0] kd, logic [31:0] k, logic [15:0] sym,
			logic [31:0] pr, logic [30:0] aq, logic ice, logic [31:0] dq, logic vis);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= kd;
		order_key <= k;
		symbol_code <= sym;
		price_ticks <= pr;
		add_quantity <= aq;
		is_iceberg <= ice;
		qty_change <= dq;
		visible_side <= vis;
		do
			@(posedge clk);
		while (in_stall);
		answers_due.push_back(apply_request(kd, k, sym, pr, aq, ice, dq, vis));
		@(negedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_VIS_SHARE: vis_share = val[16:0];
			REG_REP_SHARE: rep_share = val[16:0];
			REG_HID_MIN:   hid_min = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// result checker
	initial begin
		answer_t exp_a;
		mismatch_count = 0;
		answers_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected transaction: status %0d queried %0d total %0d",
							status, queried_quantity, order_total);
				end else begin
					exp_a = answers_due.pop_front();
					if (status !== exp_a.status || queried_quantity !== exp_a.queried
							|| order_total !== exp_a.total) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
								exp_a.status, $signed(exp_a.queried), $signed(exp_a.total),
								status, queried_quantity, order_total);
					end
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (1500) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	function automatic logic [31:0] pick_key();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 4) != 0 && book_live[s])
			return book_key[s];
		return $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 90);
	endfunction

	task automatic random_request(logic [15:0] sym_max, logic [31:0] pr_max);
		logic [2:0] kd;
		int r;
		r = $urandom_range(0, 99);
		kd = r < 35 ? KIND_ADD : r < 50 ? KIND_REMOVE : r < 75 ? KIND_MODIFY :
			r < 85 ? KIND_LEVEL : r < 98 ? KIND_QUEUE : 3'($urandom_range(5, 7));
		send_request(kd, pick_key(),
			$urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, sym_max)),
			$urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, pr_max),
			$urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 200)),
			1'($urandom_range(0, 1)),
			$urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 60)) - 30),
			1'($urandom_range(0, 1)));
	endtask

	task automatic test_reset_values();
		send_request(KIND_ADD, 32'd1, 16'd5, 32'd100, 31'd100, 1'b1, 32'd0, 1'b0);
		send_request(KIND_QUEUE, 32'd1, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b1);
		send_request(KIND_MODIFY, 32'd1, 16'd0, 32'd0, 31'd0, 1'b0, -32'd80, 1'b1);
		send_request(KIND_MODIFY, 32'd1, 16'd0, 32'd0, 31'd0, 1'b0, 32'd50, 1'b0);
		send_request(KIND_MODIFY, 32'd1, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		wait_idle();
	endtask

	task automatic test_directed();
		// extremes, duplicates, unknown ids and unused kinds
		send_request(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1,
			32'h7FFF_FFFF, 1'b1);
		send_request(KIND_ADD, 32'hFFFF_FFFF, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_ADD, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_LEVEL, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_QUEUE, 32'hFFFF_FFFF, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_MODIFY, 32'hFFFF_FFFF, 16'd0, 32'd0, 31'd0, 1'b0, 32'h8000_0000, 1'b0);
		send_request(KIND_MODIFY, 32'hFFFF_FFFF, 16'd0, 32'd0, 31'd0, 1'b0, 32'h7FFF_FFFF, 1'b1);
		send_request(KIND_MODIFY, 32'h1234, 16'd0, 32'd0, 31'd0, 1'b0, 32'd3, 1'b1);
		send_request(KIND_QUEUE, 32'h1234, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b1);
		send_request(KIND_REMOVE, 32'h1234, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(3'd5, 32'd0, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1,
			32'hFFFF_FFFF, 1'b1);
		send_request(KIND_REMOVE, 32'hFFFF_FFFF, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_REMOVE, 32'd0, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_REMOVE, 32'd1, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		wait_idle();
	endtask

	task automatic test_full_table();
		// fill every slot, then one more is refused; free a middle slot and refill it
		for (int i = 0; i < SLOTS; i++)
			send_request(KIND_ADD, 32'(1000 + i), 16'd7, 32'd9, 31'(i + 1), i[0], 32'd0, 1'b0);
		send_request(KIND_ADD, 32'd5000, 16'd7, 32'd9, 31'd1, 1'b0, 32'd0, 1'b0);
		send_request(KIND_ADD, 32'd1003, 16'd7, 32'd9, 31'd1, 1'b0, 32'd0, 1'b0);
		send_request(KIND_LEVEL, 32'd0, 16'd7, 32'd9, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_REMOVE, 32'd1010, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_ADD, 32'd5000, 16'd7, 32'd9, 31'd1, 1'b0, 32'd0, 1'b0);
		send_request(KIND_LEVEL, 32'd0, 16'd7, 32'd9, 31'd0, 1'b0, 32'd0, 1'b0);
		for (int i = 0; i < SLOTS; i++)
			send_request(KIND_REMOVE, 32'(1000 + i), 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		send_request(KIND_REMOVE, 32'd5000, 16'd0, 32'd0, 31'd0, 1'b0, 32'd0, 1'b0);
		wait_idle();
	endtask

	task automatic test_back_pressure();
		// receiver holds off while requests keep coming
		long_hold = 1'b1;
		for (int i = 0; i < 40; i++)
			random_request(16'd3, 32'd3);
		wait_idle();
	endtask

	task automatic test_random_settings();
		logic [31:0] vs;
		logic [31:0] rs;
		logic [31:0] hm;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin vs = 32'd0; rs = 32'd0; hm = 32'd0; end
				1: begin vs = 32'h1FFFF; rs = 32'h1FFFF; hm = 32'h7FFF_FFFF; end
				2: begin vs = 32'd65536; rs = 32'd65536; hm = 32'd1; end
				3: begin vs = 32'hFFFF_FFFF; rs = 32'd1; hm = 32'hFFFF_FFFF; end
				default: begin vs = $urandom; rs = $urandom; hm = $urandom_range(0, 50); end
			endcase
			write_register(REG_VIS_SHARE, vs);
			write_register(REG_REP_SHARE, rs);
			write_register(REG_HID_MIN, hm);
			for (int i = 0; i < 150; i++)
				random_request(16'd3, 32'd3);
			wait_idle();
		end
	endtask

	// stimulus
	initial begin
		long_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ADD;
		order_key = '0;
		symbol_code = '0;
		price_ticks = '0;
		add_quantity = '0;
		is_iceberg = 1'b0;
		qty_change = '0;
		visible_side = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_VIS_SHARE;
		cfg_data = '0;
		vis_share = VIS_SHARE_RESET;
		rep_share = REP_SHARE_RESET;
		hid_min = HID_MIN_RESET;
		for (int i = 0; i < SLOTS; i++)
			book_live[i] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_values();
		test_directed();
		test_full_table();
		test_back_pressure();
		test_random_settings();

		if (mismatch_count == 0 && answers_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
